// ===== src/streamline_integration_step_top_defines.svh =====
// Assertion macros used by the checker file of this block.
`ifndef STREAMLINE_INTEGRATION_STEP_TOP_DEFINES_SVH
`define STREAMLINE_INTEGRATION_STEP_TOP_DEFINES_SVH

// Implication into the next cycle, quiet while reset is held.
`define SIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sis assertion failed");

// Implication in the same cycle, quiet while reset is held.
`define SIS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sis assertion failed");

// Implication into the next cycle that also holds across reset.
`define SIS_ASSERT_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sis reset assertion failed");

`endif

// ===== src/sis_pkg.sv =====
package sis_pkg;

  localparam int STEP_FRAC = 16;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef enum logic [2:0] {
    CFG_GRID_COLS   = 3'd0,
    CFG_GRID_ROWS   = 3'd1,
    CFG_GRID_SLICES = 3'd2,
    CFG_STEP_SIZE   = 3'd3,
    CFG_METHOD      = 3'd4
  } cfg_index_t;

  typedef enum logic [1:0] {
    METHOD_EULER    = 2'd0,
    METHOD_MIDPOINT = 2'd1,
    METHOD_RK4      = 2'd2
  } method_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FETCH,
    ST_NORM,
    ST_SLOPE,
    ST_UPDATE,
    ST_DIVM,
    ST_DIVC,
    ST_FIN
  } seq_state_t;

  typedef enum logic [2:0] {
    UV_IDLE,
    UV_SCALE,
    UV_SQ,
    UV_ROOT,
    UV_DIV,
    UV_DONE
  } uv_state_t;

  // Saturate a wide signed value to 32 bits signed.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== src/sis_field_mem.sv =====
module sis_field_mem import sis_pkg::*; #(
  parameter int ADDR_W = 15,
  parameter int DATA_W = 48,
  parameter int DEPTH  = 32768
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/sis_unitvec.sv =====
module sis_unitvec import sis_pkg::*; #(
  parameter int COMP_BITS = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [COMP_BITS-1:0] a [3],
  output logic signed [FRAC_BITS+1:0] u [3],
  output logic                        done
);

  localparam int UW = FRAC_BITS + 2;
  localparam int QW = FRAC_BITS + 1;
  localparam int CW = $clog2(QW + 1) > 2 ? $clog2(QW + 1) : 2;

  uv_state_t state_r, state_nxt;

  logic signed [31:0] v_r [3];
  logic [31:0]        mx_r;
  logic [63:0]        acc_r;
  logic [63:0]        x_r;
  logic [63:0]        rt_r;
  logic [63:0]        bit_r;
  logic [33:0]        rem_r [3];
  logic [QW-1:0]      q_r [3];
  logic signed [UW-1:0] u_r [3];
  logic [CW-1:0]      cnt_r;

  logic [31:0] mag [3];
  logic [31:0] amag [3];
  logic [31:0] amax;
  logic [63:0] sq;
  logic [63:0] trial;
  logic        last_root;
  logic        last_div;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      amag[c] = a[c] < 0 ? 32'(-33'(a[c])) : 32'(a[c]);
      mag[c]  = v_r[c] < 0 ? 32'(-33'(v_r[c])) : 32'(v_r[c]);
    end
    amax = amag[0];
    if (amag[1] > amax) amax = amag[1];
    if (amag[2] > amax) amax = amag[2];
    sq        = 64'(mag[cnt_r[1:0]]) * 64'(mag[cnt_r[1:0]]);
    trial     = rt_r + bit_r;
    last_root = bit_r[0];
    last_div  = (cnt_r == CW'(QW - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= UV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      UV_IDLE: begin
        if (start) state_nxt = UV_SCALE;
      end
      UV_SCALE: begin
        if (mx_r == 32'd0) begin
          state_nxt = UV_DONE;
        end else if (mx_r >= 32'h4000_0000 && mx_r < 32'h8000_0000) begin
          state_nxt = UV_SQ;
        end
      end
      UV_SQ: begin
        if (cnt_r == CW'(2)) state_nxt = UV_ROOT;
      end
      UV_ROOT: begin
        if (last_root) state_nxt = UV_DIV;
      end
      UV_DIV: begin
        if (last_div) state_nxt = UV_DONE;
      end
      UV_DONE: state_nxt = UV_IDLE;
      default: state_nxt = UV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      UV_IDLE: begin
        if (start) begin
          for (int c = 0; c < 3; c++) v_r[c] <= 32'(a[c]);
          mx_r <= amax;
        end
      end
      UV_SCALE: begin
        cnt_r <= '0;
        acc_r <= '0;
        if (mx_r == 32'd0) begin
          for (int c = 0; c < 3; c++) u_r[c] <= '0;
        end else if (mx_r < 32'h0040_0000) begin
          // Eight single-bit steps at once; still lands below the window.
          mx_r <= mx_r << 8;
          for (int c = 0; c < 3; c++) v_r[c] <= v_r[c] <<< 8;
        end else if (mx_r < 32'h4000_0000) begin
          mx_r <= mx_r << 1;
          for (int c = 0; c < 3; c++) v_r[c] <= v_r[c] <<< 1;
        end else if (mx_r >= 32'h8000_0000) begin
          mx_r <= mx_r >> 1;
          for (int c = 0; c < 3; c++) v_r[c] <= v_r[c] >>> 1;
        end
      end
      UV_SQ: begin
        cnt_r <= cnt_r + CW'(1);
        acc_r <= acc_r + sq;
        if (cnt_r == CW'(2)) begin
          x_r   <= acc_r + sq;
          rt_r  <= '0;
          bit_r <= 64'd1 << 62;
        end
      end
      UV_ROOT: begin
        cnt_r <= '0;
        if (x_r >= trial) begin
          x_r  <= x_r - trial;
          rt_r <= (rt_r >> 1) + bit_r;
        end else begin
          rt_r <= rt_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (last_root) begin
          for (int c = 0; c < 3; c++) begin
            rem_r[c] <= 34'(mag[c]);
            q_r[c]   <= '0;
          end
        end
      end
      UV_DIV: begin
        cnt_r <= cnt_r + CW'(1);
        for (int c = 0; c < 3; c++) begin
          logic          hit;
          logic [33:0]   r;
          logic [QW-1:0] qn;
          hit = rem_r[c] >= rt_r[33:0];
          r   = hit ? rem_r[c] - rt_r[33:0] : rem_r[c];
          qn  = {q_r[c][QW-2:0], hit};
          rem_r[c] <= r << 1;
          q_r[c]   <= qn;
          if (last_div) begin
            u_r[c] <= v_r[c] < 0 ? -UW'(qn) : UW'(qn);
          end
        end
      end
      UV_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign done = (state_r == UV_DONE);
  always_comb begin
    for (int c = 0; c < 3; c++) u[c] = u_r[c];
  end

endmodule

// ===== src/streamline_integration_step_top.sv =====
// Streamline integration step over a stored 3D vector field.
//
// The input channel takes a request when start is high and busy is low.
// A request with in_operation low writes one field sample (in_comp_*) at
// grid index in_sample_*; it finishes in the cycle it is taken, returns no
// result, and busy stays low. A request with in_operation high performs one
// step from in_pos_* and returns one result: out_valid is high for exactly
// one cycle with out_next_* and out_in_bounds. The receiver cannot stall,
// so each result must be taken in that cycle.
// A step runs one to four derivative evaluations (Euler, midpoint, RK4).
// Each evaluation is a bounds check, eight reads of the single field memory
// port with trilinear interpolation, then the normalizer: a scale search,
// the squares, a square root and a division to FRAC_BITS+1 quotient bits.
// A failed bounds check ends the step early. One step runs at a time; busy
// is high while it does. Reset returns the sequencer to idle and loads the
// register defaults; the field memory is not cleared, and unwritten samples
// are undefined.
module streamline_integration_step_top import sis_pkg::*; #(
  parameter int GRID_SIDE = 32,
  parameter int COMP_BITS = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_operation,
  input  logic [$clog2(GRID_SIDE)-1:0] in_sample_x,
  input  logic [$clog2(GRID_SIDE)-1:0] in_sample_y,
  input  logic [$clog2(GRID_SIDE)-1:0] in_sample_z,
  input  logic signed [COMP_BITS-1:0] in_comp_x,
  input  logic signed [COMP_BITS-1:0] in_comp_y,
  input  logic signed [COMP_BITS-1:0] in_comp_z,
  input  logic signed [31:0]          in_pos_x,
  input  logic signed [31:0]          in_pos_y,
  input  logic signed [31:0]          in_pos_z,
  output logic                        out_valid,
  output logic signed [31:0]          out_next_x,
  output logic signed [31:0]          out_next_y,
  output logic signed [31:0]          out_next_z,
  output logic                        out_in_bounds,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [19:0]                 cfg_wdata
);

  localparam int IDX_W  = $clog2(GRID_SIDE);
  localparam int DEPTH  = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int DW     = 3 * COMP_BITS;
  localparam int UW     = FRAC_BITS + 2;
  localparam int KW     = FRAC_BITS + 5;
  localparam int AW     = KW + 3;
  localparam int MW     = AW - 1;
  localparam int SHIFT6 = MW + 2;
  localparam longint unsigned RECIP6 = (64'd1 << SHIFT6) / 64'd6;
  localparam int LPW    = COMP_BITS + FRAC_BITS + 2;
  localparam int SPW    = 21 + UW;
  localparam logic [3:0] FETCH_LAST = 4'd10;

  // Configuration registers.
  logic [5:0]  grid_cols_r, grid_rows_r, grid_slices_r;
  logic [19:0] step_r;
  logic [1:0]  method_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r   <= 6'd32;
      grid_rows_r   <= 6'd32;
      grid_slices_r <= 6'd32;
      step_r        <= 20'd16384;
      method_r      <= METHOD_RK4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_COLS:   grid_cols_r   <= cfg_wdata[5:0];
        CFG_GRID_ROWS:   grid_rows_r   <= cfg_wdata[5:0];
        CFG_GRID_SLICES: grid_slices_r <= cfg_wdata[5:0];
        CFG_STEP_SIZE:   step_r        <= cfg_wdata;
        CFG_METHOD:      method_r      <= cfg_wdata[1:0];
        default: begin
        end
      endcase
    end
  end

  seq_state_t state_r, state_nxt;

  logic signed [31:0]        p_r [3];
  logic signed [31:0]        t_r [3];
  logic [1:0]                stage_r;
  logic [3:0]                cnt_r;
  logic [IDX_W-1:0]          lo_r [3];
  logic                      fl_r [3];
  logic [FRAC_BITS-1:0]      w_r [3];
  logic signed [COMP_BITS-1:0] ev_r [3];
  logic signed [COMP_BITS-1:0] l0_r [3];
  logic signed [COMP_BITS-1:0] l1_r [3];
  logic signed [COMP_BITS-1:0] y0_r [3];
  logic signed [COMP_BITS-1:0] y1_r [3];
  logic signed [COMP_BITS-1:0] a_r [3];
  logic                      uv_start_r;
  logic signed [KW-1:0]      k_r [3];
  logic signed [AW-1:0]      acc_r [3];
  logic [MW-1:0]             mag_r [3];
  logic                      neg_r [3];
  logic [2*MW-1:0]           prod_r [3];
  logic signed [AW-1:0]      quo_r [3];
  logic signed [31:0]        next_r [3];
  logic                      ok_r;
  logic                      out_valid_r;

  logic signed [UW-1:0]      u [3];
  logic                      uv_done;
  logic [DW-1:0]             rd_data;
  logic                      wr_en;
  logic [ADDR_W-1:0]         wr_addr;
  logic                      rd_en;
  logic [ADDR_W-1:0]         rd_addr;

  // Cell of the current evaluation point and its bounds check.
  logic signed [33:0] lo_full [3];
  logic signed [33:0] hi_full [3];
  logic signed [33:0] lim [3];
  logic [5:0]         dim_reg [3];
  logic               cell_fail;

  always_comb begin
    dim_reg[0] = grid_cols_r;
    dim_reg[1] = grid_rows_r;
    dim_reg[2] = grid_slices_r;
    cell_fail  = 1'b0;
    for (int c = 0; c < 3; c++) begin
      lo_full[c] = 34'(t_r[c] >>> FRAC_BITS);
      hi_full[c] = lo_full[c] + 34'(|t_r[c][FRAC_BITS-1:0]);
      lim[c]     = (32'(dim_reg[c]) > GRID_SIDE) ? 34'(GRID_SIDE) : 34'(dim_reg[c]);
      if (lo_full[c] < 0 || hi_full[c] >= lim[c]) cell_fail = 1'b1;
    end
  end

  // Corner address for the read issued in this fetch cycle.
  logic [IDX_W-1:0] cx, cy, cz;
  always_comb begin
    cx = lo_r[0] + IDX_W'(cnt_r[0] & fl_r[0]);
    cy = lo_r[1] + IDX_W'(cnt_r[1] & fl_r[1]);
    cz = lo_r[2] + IDX_W'(cnt_r[2] & fl_r[2]);
    rd_addr = (ADDR_W'(cz) * ADDR_W'(GRID_SIDE) + ADDR_W'(cy)) * ADDR_W'(GRID_SIDE)
              + ADDR_W'(cx);
    rd_en   = (state_r == ST_FETCH) && !cnt_r[3];
  end

  // Field sample writes land in the idle cycle that takes the request.
  always_comb begin
    wr_en   = start && !busy && (in_operation == OP_WRITE) &&
              (32'(in_sample_x) < GRID_SIDE) && (32'(in_sample_y) < GRID_SIDE) &&
              (32'(in_sample_z) < GRID_SIDE);
    wr_addr = (ADDR_W'(in_sample_z) * ADDR_W'(GRID_SIDE) + ADDR_W'(in_sample_y))
              * ADDR_W'(GRID_SIDE) + ADDR_W'(in_sample_x);
  end

  sis_field_mem #(
    .ADDR_W(ADDR_W),
    .DATA_W(DW),
    .DEPTH (DEPTH)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data({in_comp_z, in_comp_y, in_comp_x}),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Shared interpolation unit, one lerp per component each cycle. Its
  // operands follow the fetch schedule: x pairs as the odd corners arrive,
  // y pairs once both x results are in, z last.
  logic signed [COMP_BITS-1:0] la [3];
  logic signed [COMP_BITS-1:0] lb [3];
  logic [FRAC_BITS-1:0]        lw [3];
  logic signed [COMP_BITS-1:0] lres [3];
  logic signed [COMP_BITS-1:0] rd_comp [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic signed [COMP_BITS:0] diff;
      logic signed [LPW-1:0]     prod;
      rd_comp[c] = rd_data[c*COMP_BITS +: COMP_BITS];
      unique case (cnt_r)
        4'd5, 4'd9: begin
          la[c] = l0_r[c];
          lb[c] = l1_r[c];
          lw[c] = w_r[1];
        end
        FETCH_LAST: begin
          la[c] = y0_r[c];
          lb[c] = y1_r[c];
          lw[c] = w_r[2];
        end
        default: begin
          la[c] = ev_r[c];
          lb[c] = rd_comp[c];
          lw[c] = w_r[0];
        end
      endcase
      diff    = (COMP_BITS+1)'(lb[c]) - (COMP_BITS+1)'(la[c]);
      prod    = LPW'(diff) * LPW'($signed({1'b0, lw[c]}));
      lres[c] = COMP_BITS'(LPW'(la[c]) + (prod >>> FRAC_BITS));
    end
  end

  sis_unitvec #(
    .COMP_BITS(COMP_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_unitvec (
    .clk  (clk),
    .rst_n(rst_n),
    .start(uv_start_r),
    .a    (a_r),
    .u    (u),
    .done (uv_done)
  );

  // Slope, next evaluation points and final positions.
  logic signed [KW-1:0] k_nxt [3];
  logic signed [31:0]   half_pt [3];
  logic signed [31:0]   full_pt [3];
  logic signed [31:0]   fin_pt [3];
  logic [MW-1:0]        q0 [3];
  logic [MW+3:0]        rem6 [3];
  logic [MW-1:0]        qq [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic signed [SPW-1:0] sp;
      sp         = SPW'($signed({1'b0, step_r})) * SPW'(u[c]);
      k_nxt[c]   = sp[STEP_FRAC +: KW];
      half_pt[c] = sat32(64'(p_r[c]) + 64'(k_r[c] >>> 1));
      full_pt[c] = sat32(64'(p_r[c]) + 64'(k_r[c]));
      fin_pt[c]  = sat32(64'(p_r[c]) + 64'(quo_r[c]));
      q0[c]      = MW'(prod_r[c] >> SHIFT6);
      rem6[c]    = (MW+4)'(mag_r[c]) - (MW+4)'(q0[c]) * (MW+4)'(6);
      qq[c]      = q0[c] + MW'(rem6[c] >= (MW+4)'(6));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && in_operation == OP_STEP) state_nxt = ST_CHECK;
      end
      ST_CHECK: state_nxt = cell_fail ? ST_IDLE : ST_FETCH;
      ST_FETCH: begin
        if (cnt_r == FETCH_LAST) state_nxt = ST_NORM;
      end
      ST_NORM: begin
        if (uv_done) state_nxt = ST_SLOPE;
      end
      ST_SLOPE: state_nxt = ST_UPDATE;
      ST_UPDATE: begin
        unique case (stage_r)
          2'd0: state_nxt = (method_r == METHOD_EULER) ? ST_IDLE : ST_CHECK;
          2'd1: state_nxt = (method_r == METHOD_MIDPOINT) ? ST_IDLE : ST_CHECK;
          2'd2: state_nxt = ST_CHECK;
          default: state_nxt = ST_DIVM;
        endcase
      end
      ST_DIVM: state_nxt = ST_DIVC;
      ST_DIVC: state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      uv_start_r  <= 1'b0;
    end else begin
      out_valid_r <= ((state_r == ST_CHECK) && cell_fail) ||
                     ((state_r == ST_UPDATE) &&
                      (((stage_r == 2'd0) && (method_r == METHOD_EULER)) ||
                       ((stage_r == 2'd1) && (method_r == METHOD_MIDPOINT)))) ||
                     (state_r == ST_FIN);
      uv_start_r  <= (state_r == ST_FETCH) && (cnt_r == FETCH_LAST);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (start && in_operation == OP_STEP) begin
          p_r[0] <= in_pos_x;
          p_r[1] <= in_pos_y;
          p_r[2] <= in_pos_z;
          t_r[0] <= in_pos_x;
          t_r[1] <= in_pos_y;
          t_r[2] <= in_pos_z;
          stage_r <= 2'd0;
        end
      end
      ST_CHECK: begin
        cnt_r <= 4'd0;
        for (int c = 0; c < 3; c++) begin
          lo_r[c] <= lo_full[c][IDX_W-1:0];
          fl_r[c] <= |t_r[c][FRAC_BITS-1:0];
          w_r[c]  <= t_r[c][FRAC_BITS-1:0];
        end
        if (cell_fail) begin
          next_r <= p_r;
          ok_r   <= 1'b0;
        end
      end
      ST_FETCH: begin
        cnt_r <= cnt_r + 4'd1;
        for (int c = 0; c < 3; c++) begin
          unique case (cnt_r)
            4'd1, 4'd3, 4'd7: ev_r[c] <= rd_comp[c];
            4'd5: begin
              ev_r[c] <= rd_comp[c];
              y0_r[c] <= lres[c];
            end
            4'd2, 4'd6: l0_r[c] <= lres[c];
            4'd4, 4'd8: l1_r[c] <= lres[c];
            4'd9:       y1_r[c] <= lres[c];
            FETCH_LAST: a_r[c]  <= lres[c];
            default: begin
            end
          endcase
        end
      end
      ST_NORM: begin
      end
      ST_SLOPE: begin
        k_r <= k_nxt;
      end
      ST_UPDATE: begin
        stage_r <= stage_r + 2'd1;
        for (int c = 0; c < 3; c++) begin
          unique case (stage_r)
            2'd0: begin
              acc_r[c]  <= AW'(k_r[c]);
              t_r[c]    <= half_pt[c];
              next_r[c] <= full_pt[c];
            end
            2'd1: begin
              acc_r[c]  <= acc_r[c] + (AW'(k_r[c]) <<< 1);
              t_r[c]    <= half_pt[c];
              next_r[c] <= full_pt[c];
            end
            2'd2: begin
              acc_r[c] <= acc_r[c] + (AW'(k_r[c]) <<< 1);
              t_r[c]   <= full_pt[c];
            end
            default: acc_r[c] <= acc_r[c] + AW'(k_r[c]);
          endcase
        end
        ok_r <= 1'b1;
      end
      ST_DIVM: begin
        // Division by six as a multiply by the scaled reciprocal.
        for (int c = 0; c < 3; c++) begin
          logic [MW-1:0] m;
          m = acc_r[c] < 0 ? MW'(-acc_r[c]) : MW'(acc_r[c]);
          mag_r[c]  <= m;
          neg_r[c]  <= acc_r[c] < 0;
          prod_r[c] <= (2*MW)'(m) * (2*MW)'(RECIP6);
        end
      end
      ST_DIVC: begin
        // The reciprocal product is short by at most one; fix it here.
        for (int c = 0; c < 3; c++) begin
          quo_r[c] <= neg_r[c] ? -AW'(qq[c]) : AW'(qq[c]);
        end
      end
      ST_FIN: begin
        next_r <= fin_pt;
      end
      default: begin
      end
    endcase
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_next_x    = next_r[0];
  assign out_next_y    = next_r[1];
  assign out_next_z    = next_r[2];
  assign out_in_bounds = ok_r;

endmodule

// ===== src/sis_checker.sv =====
`include "streamline_integration_step_top_defines.svh"

module sis_checker import sis_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_operation,
  input logic out_valid
);

  // Reset leaves the block idle with no result on the way.
  `SIS_ASSERT_RST(a_reset_quiet, clk, !rst_n, !out_valid && !busy)

  // A taken step request occupies the block in the next cycle.
  `SIS_ASSERT_NEXT(a_step_busy, clk, rst_n, start && !busy && in_operation == OP_STEP, busy)

  // A sample write neither occupies the block nor produces a result.
  `SIS_ASSERT_NEXT(a_write_quiet, clk, rst_n, start && !busy && in_operation == OP_WRITE, !busy && !out_valid)

  // A result is shown once, when the block has gone back to idle.
  `SIS_ASSERT_SAME(a_result_idle, clk, rst_n, out_valid, !busy)
  `SIS_ASSERT_NEXT(a_result_single, clk, rst_n, out_valid, !out_valid)

endmodule

bind streamline_integration_step_top sis_checker u_sis_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_operation(in_operation),
  .out_valid   (out_valid)
);

// ===== tb/tb_streamline_integration_step_top.sv =====
`timescale 1ns/1ps
module tb_streamline_integration_step_top;
  import sis_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE      = 32;
  localparam int DEPTH     = SIDE * SIDE * SIDE;
  localparam int FRAC      = 16;
  localparam int STALL_MAX = 6000;
  localparam int SETTLE    = 20;

  // One request as the sender presents it.
  typedef struct {
    logic               op;
    logic [4:0]         sx, sy, sz;
    logic signed [15:0] cx, cy, cz;
    logic signed [31:0] px, py, pz;
  } request_t;

  // One step result as the block should return it.
  typedef struct {
    logic signed [31:0] nx, ny, nz;
    logic               ok;
  } next_pos_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_operation = 1'b0;
  logic [4:0] in_sample_x = '0, in_sample_y = '0, in_sample_z = '0;
  logic signed [15:0] in_comp_x = '0, in_comp_y = '0, in_comp_z = '0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic out_valid;
  logic signed [31:0] out_next_x, out_next_y, out_next_z;
  logic out_in_bounds;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [19:0] cfg_wdata = '0;

  streamline_integration_step_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation),
    .in_sample_x(in_sample_x), .in_sample_y(in_sample_y), .in_sample_z(in_sample_z),
    .in_comp_x(in_comp_x), .in_comp_y(in_comp_y), .in_comp_z(in_comp_z),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .out_valid(out_valid), .out_next_x(out_next_x), .out_next_y(out_next_y),
    .out_next_z(out_next_z), .out_in_bounds(out_in_bounds),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Shadow copy of the block's registers and field memory.
  logic [5:0]  cols_r = 6'd32, rows_r = 6'd32, slices_r = 6'd32;
  logic [19:0] step_r = 20'd16384;
  logic [1:0]  method_r = METHOD_RK4;
  logic signed [15:0] field_x [DEPTH];
  logic signed [15:0] field_y [DEPTH];
  logic signed [15:0] field_z [DEPTH];

  request_t  pending_q[$];
  next_pos_t next_pos_q[$];
  request_t  cur;
  int idle_pct = 0;
  int errors = 0;
  int steps_done = 0, writes_done = 0, fails_seen = 0;
  int quiet_cycles = 0;

  function automatic longint dim_limit(input logic [5:0] r);
    return (r > SIDE) ? SIDE : longint'(r);
  endfunction

  function automatic longint lerp(input longint a, input longint b, input longint w);
    return a + (((b - a) * w) >>> FRAC);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic longint sat_pos(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Scaled unit field direction at p; returns 0 if a cell leaves the grid.
  function automatic bit field_slope(input longint p[3], output longint k[3]);
    longint lo[3], hi[3], w[3], lim[3], v[8][3], a[3], u[3];
    longint xi, yi, zi, addr, y0, y1;
    longint unsigned mx, m, sum, n;
    lim[0] = dim_limit(cols_r);
    lim[1] = dim_limit(rows_r);
    lim[2] = dim_limit(slices_r);
    for (int i = 0; i < 3; i++) begin
      lo[i] = p[i] >>> FRAC;
      w[i]  = p[i] & 64'hFFFF;
      hi[i] = lo[i] + ((w[i] != 0) ? 1 : 0);
      if (lo[i] < 0 || hi[i] >= lim[i]) return 1'b0;
    end
    for (int i = 0; i < 8; i++) begin
      xi = (i & 1) ? hi[0] : lo[0];
      yi = (i & 2) ? hi[1] : lo[1];
      zi = (i & 4) ? hi[2] : lo[2];
      addr = (zi * SIDE + yi) * SIDE + xi;
      v[i][0] = field_x[addr];
      v[i][1] = field_y[addr];
      v[i][2] = field_z[addr];
    end
    mx = 0;
    for (int c = 0; c < 3; c++) begin
      y0 = lerp(lerp(v[0][c], v[1][c], w[0]), lerp(v[2][c], v[3][c], w[0]), w[1]);
      y1 = lerp(lerp(v[4][c], v[5][c], w[0]), lerp(v[6][c], v[7][c], w[0]), w[1]);
      a[c] = lerp(y0, y1, w[2]);
      m = (a[c] < 0) ? longint'(-a[c]) : longint'(a[c]);
      if (m > mx) mx = m;
    end
    if (mx == 0) begin
      for (int c = 0; c < 3; c++) u[c] = 0;
    end else begin
      while (mx < (64'd1 << 30)) begin
        mx <<= 1;
        for (int c = 0; c < 3; c++) a[c] = a[c] * 2;
      end
      while (mx >= (64'd1 << 31)) begin
        mx >>= 1;
        for (int c = 0; c < 3; c++) a[c] = a[c] >>> 1;
      end
      sum = 0;
      for (int c = 0; c < 3; c++) begin
        m = (a[c] < 0) ? longint'(-a[c]) : longint'(a[c]);
        sum += m * m;
      end
      n = int_sqrt(sum);
      for (int c = 0; c < 3; c++) u[c] = (a[c] * 65536) / longint'(n);
    end
    for (int c = 0; c < 3; c++) k[c] = (longint'(step_r) * u[c]) >>> STEP_FRAC;
    return 1'b1;
  endfunction

  // Full integration step under the current method.
  function automatic next_pos_t integrate_step(input request_t r);
    longint p[3], t[3], k1[3], k2[3], k3[3], k4[3], q[3];
    next_pos_t res;
    bit ok;
    p[0] = r.px; p[1] = r.py; p[2] = r.pz;
    ok = field_slope(p, k1);
    if (ok && method_r == METHOD_EULER) begin
      for (int c = 0; c < 3; c++) q[c] = sat_pos(p[c] + k1[c]);
    end else if (ok) begin
      for (int c = 0; c < 3; c++) t[c] = sat_pos(p[c] + (k1[c] >>> 1));
      ok = field_slope(t, k2);
      if (ok && method_r == METHOD_MIDPOINT) begin
        for (int c = 0; c < 3; c++) q[c] = sat_pos(p[c] + k2[c]);
      end else if (ok) begin
        for (int c = 0; c < 3; c++) t[c] = sat_pos(p[c] + (k2[c] >>> 1));
        ok = field_slope(t, k3);
        if (ok) begin
          for (int c = 0; c < 3; c++) t[c] = sat_pos(p[c] + k3[c]);
          ok = field_slope(t, k4);
        end
        if (ok) begin
          for (int c = 0; c < 3; c++)
            q[c] = sat_pos(p[c] + (k1[c] + 2 * k2[c] + 2 * k3[c] + k4[c]) / 6);
        end
      end
    end
    if (!ok) begin
      for (int c = 0; c < 3; c++) q[c] = p[c];
    end
    res.nx = q[0][31:0];
    res.ny = q[1][31:0];
    res.nz = q[2][31:0];
    res.ok = ok;
    return res;
  endfunction

  // Driver: a request is taken at an edge where start is high and busy is low.
  // The same edge loads the next request, or lowers start, never both.
  always @(posedge clk) begin
    request_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (cur.op == OP_WRITE) begin
          field_x[{cur.sz, cur.sy, cur.sx}] = cur.cx;
          field_y[{cur.sz, cur.sy, cur.sx}] = cur.cy;
          field_z[{cur.sz, cur.sy, cur.sx}] = cur.cz;
          writes_done++;
        end else begin
          next_pos_q.push_back(integrate_step(cur));
          steps_done++;
        end
      end
      if (!start || !busy) begin
        if (pending_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          nxt = pending_q.pop_front();
          cur = nxt;
          start <= 1'b1;
          in_operation <= nxt.op;
          in_sample_x <= nxt.sx;
          in_sample_y <= nxt.sy;
          in_sample_z <= nxt.sz;
          in_comp_x <= nxt.cx;
          in_comp_y <= nxt.cy;
          in_comp_z <= nxt.cz;
          in_pos_x <= nxt.px;
          in_pos_y <= nxt.py;
          in_pos_z <= nxt.pz;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest prediction. The
  // watchdog counts cycles with work outstanding and no handshake.
  always @(posedge clk) begin
    next_pos_t exp_r;
    if (rst_n) begin
      if (out_valid) begin
        if (next_pos_q.size() == 0) begin
          $error("result with no step outstanding");
          errors++;
        end else begin
          exp_r = next_pos_q.pop_front();
          if (!exp_r.ok) fails_seen++;
          if (out_next_x !== exp_r.nx) begin
            $error("next_x expected %0d got %0d", exp_r.nx, out_next_x);
            errors++;
          end
          if (out_next_y !== exp_r.ny) begin
            $error("next_y expected %0d got %0d", exp_r.ny, out_next_y);
            errors++;
          end
          if (out_next_z !== exp_r.nz) begin
            $error("next_z expected %0d got %0d", exp_r.nz, out_next_z);
            errors++;
          end
          if (out_in_bounds !== exp_r.ok) begin
            $error("in_bounds expected %0d got %0d", exp_r.ok, out_in_bounds);
            errors++;
          end
        end
      end
      if (out_valid || (start && !busy) || (next_pos_q.size() == 0 && !start)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_MAX) begin
        $display("** streamline_integration_step_top: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Register write; only called while the block is idle.
  task automatic write_reg(input cfg_index_t idx, input logic [19:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_GRID_COLS:   cols_r = val[5:0];
      CFG_GRID_ROWS:   rows_r = val[5:0];
      CFG_GRID_SLICES: slices_r = val[5:0];
      CFG_STEP_SIZE:   step_r = val;
      CFG_METHOD:      method_r = val[1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every queued request is taken and every result is back,
  // then let the block settle.
  task automatic drain();
    while (pending_q.size() != 0 || start || next_pos_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic request_t write_req(input int x, input int y, input int z,
                                         input logic [15:0] vx, input logic [15:0] vy,
                                         input logic [15:0] vz);
    request_t r;
    r = '{default: '0};
    r.op = OP_WRITE;
    r.sx = x; r.sy = y; r.sz = z;
    r.cx = vx; r.cy = vy; r.cz = vz;
    r.px = $urandom(); r.py = $urandom(); r.pz = $urandom();
    return r;
  endfunction

  function automatic request_t step_req(input logic [31:0] x, input logic [31:0] y,
                                        input logic [31:0] z);
    request_t r;
    r.op = OP_STEP;
    r.sx = $urandom(); r.sy = $urandom(); r.sz = $urandom();
    r.cx = $urandom(); r.cy = $urandom(); r.cz = $urandom();
    r.px = x; r.py = y; r.pz = z;
    return r;
  endfunction

  // Mostly a position inside the grid in use, sometimes on a sample, sometimes just past its far edge, else anything.
  function automatic logic [31:0] grid_pos(input logic [5:0] dreg);
    int d, pick;
    logic [31:0] v;
    d = (dreg > SIDE) ? SIDE : dreg;
    pick = $urandom_range(0, 99);
    if (pick < 80 && d > 0) begin
      v = {16'($urandom_range(0, d - 1)), 16'($urandom())};
      if (pick < 15) v[15:0] = '0;
    end else if (pick < 88) begin
      v = {16'($urandom_range(d, d + 1)), 16'($urandom())};
    end else begin
      v = $urandom();
    end
    return v;
  endfunction

  typedef struct {
    logic [5:0]  cols, rows, slices;
    logic [19:0] step;
    logic [1:0]  meth;
    int          idle;
  } phase_t;

  phase_t phases[7];

  initial begin
    phases[0] = '{6'd32, 6'd32, 6'd32, 20'd16384,   METHOD_RK4,      0};
    phases[1] = '{6'd32, 6'd32, 6'd32, 20'd65536,   METHOD_EULER,    45};
    phases[2] = '{6'd8,  6'd5,  6'd3,  20'hFFFFF,   METHOD_MIDPOINT, 11};
    phases[3] = '{6'd1,  6'd1,  6'd1,  20'd0,       METHOD_RK4,      45};
    phases[4] = '{6'd40, 6'd32, 6'd2,  20'd200000,  2'd3,            0};
    phases[5] = '{6'd0,  6'd32, 6'd32, 20'd16384,   METHOD_EULER,    45};
    phases[6] = '{6'd63, 6'd63, 6'd63, 20'd300000,  METHOD_RK4,      11};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every sample is written before any step, so no step ever reads a
    // sample that was never written.
    for (int a = 0; a < DEPTH; a++)
      pending_q.push_back(write_req(a % SIDE, (a / SIDE) % SIDE, a / (SIDE * SIDE),
                                    $urandom(), $urandom(), $urandom()));
    drain();

    // Directed requests under the reset register values.
    for (int a = 0; a < 8; a++)
      pending_q.push_back(write_req(a & 1, (a >> 1) & 1, a >> 2, 16'h0, 16'h0, 16'h0));
    // A zero field around the origin gives a zero direction: no motion.
    pending_q.push_back(step_req(32'h0, 32'h0, 32'h0));
    pending_q.push_back(step_req(32'h8000, 32'h8000, 32'h8000));
    // Component extremes at two samples, then a step on the first of them and one more step.
    pending_q.push_back(write_req(31, 31, 31, 16'h7FFF, 16'h8000, 16'h7FFF));
    pending_q.push_back(write_req(30, 31, 31, 16'h8000, 16'h7FFF, 16'h8000));
    pending_q.push_back(step_req(32'h1F_0000, 32'h1F_0000, 32'h1F_0000));
    pending_q.push_back(step_req(32'h1E_8000, 32'h1E_0000, 32'h1D_C000));
    // Cells leaving the grid: past the top edge, below zero, position extremes; then one step inside.
    pending_q.push_back(step_req(32'h1F_8000, 32'h10_0000, 32'h10_0000));
    pending_q.push_back(step_req(32'hFFFF_8000, 32'h1_0000, 32'h1_0000));
    pending_q.push_back(step_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    pending_q.push_back(step_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    pending_q.push_back(step_req(32'h5_1234, 32'h7_ABCD, 32'h2_0001));
    drain();

    foreach (phases[ph]) begin
      idle_pct = 0;
      write_reg(CFG_GRID_COLS,   phases[ph].cols);
      write_reg(CFG_GRID_ROWS,   phases[ph].rows);
      write_reg(CFG_GRID_SLICES, phases[ph].slices);
      write_reg(CFG_STEP_SIZE,   phases[ph].step);
      write_reg(CFG_METHOD,      phases[ph].meth);
      idle_pct = phases[ph].idle;
      for (int n = 0; n < 185; n++) begin
        if ($urandom_range(0, 99) < 25)
          pending_q.push_back(write_req($urandom(), $urandom(), $urandom(),
                                        $urandom(), $urandom(), $urandom()));
        else
          pending_q.push_back(step_req(grid_pos(cols_r), grid_pos(rows_r),
                                       grid_pos(slices_r)));
      end
      drain();
    end

    $display("Ran %0d steps (%0d out of bounds) and %0d sample writes", steps_done,
             fails_seen, writes_done);
    $display("over seven register settings: all methods, edge dimensions and step sizes.");
    if (errors == 0 && next_pos_q.size() == 0) begin
      $display("** streamline_integration_step_top: PASSED **");
    end else begin
      $display("** streamline_integration_step_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/sis_pkg.sv
src/sis_field_mem.sv
src/sis_unitvec.sv
src/streamline_integration_step_top.sv
src/sis_checker.sv
tb/tb_streamline_integration_step_top.sv
